@@ design/mau_pkg.sv @@
package mau_pkg;

    localparam int KIND_W = 3;
    localparam int OPND_W = 64;
    localparam int EXP_W  = 63;
    localparam int MOD_W  = 31;
    localparam int SGN_W  = 34;   // Bezout coefficients and q*v, |x| <= 2*modulus
    localparam int CNT_W  = 6;

    localparam logic [MOD_W-1:0] RESET_MODULUS = 31'd1000000007;

    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NEG = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POW = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_FIX,
        ST_OP,
        ST_MUL,
        ST_PCHK,
        ST_PMUL,
        ST_ECHK,
        ST_EDIV,
        ST_EUPD,
        ST_INV,
        ST_DONE
    } t_state;

    // One MSB-first step of a serial modular multiply: acc = 2*acc + bit*x mod m.
    function automatic logic [MOD_W-1:0] mm_step(
        input logic [MOD_W-1:0] acc,
        input logic [MOD_W-1:0] x,
        input logic             y_bit,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W:0] t;
        logic [MOD_W:0] s;
        t = {acc, 1'b0};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        s = t + (y_bit ? {1'b0, x} : '0);
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[MOD_W-1:0];
    endfunction

endpackage

@@ design/mau_in_if.sv @@
interface mau_in_if import mau_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [OPND_W-1:0] operand_a;
    logic [OPND_W-1:0] operand_b;
    logic [EXP_W-1:0]  exponent;

    modport source (output valid, kind, operand_a, operand_b, exponent, input ready);
    modport sink   (input valid, kind, operand_a, operand_b, exponent, output ready);
endinterface

@@ design/mau_out_if.sv @@
interface mau_out_if import mau_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

@@ design/modular_arithmetic_unit.sv @@
// Path from the accept edge: both operands reduce bit-serially and fold their signs; then
// add/sub/neg/spare kinds finish, mul runs one serial multiply, div runs Euclid steps and a
// multiply, power runs a paired multiply per exponent bit up to the top set bit; a modulus below 2 skips to done.
// Throughput: one item at a time, set by the bit-serial reducer, divider and the
// two multiply lanes; a finished result waits in the output register meanwhile.
// Reset: synchronous active low; modulus returns to 1000000007, control idles.
module modular_arithmetic_unit import mau_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [MOD_W-1:0] i_cfg_wdata,
    mau_in_if.sink           i_in,
    mau_out_if.source        o_out
);

    t_state r_state, n_state;

    logic [MOD_W-1:0]  r_modulus;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [KIND_W-1:0] r_kind, n_kind;

    // operand reduction: magnitudes shift out MSB first into remainders
    logic [OPND_W-1:0] r_sa, n_sa, r_sb, n_sb;
    logic              r_nega, n_nega, r_negb, n_negb;
    logic [MOD_W-1:0]  r_ra, n_ra, r_rb, n_rb;
    logic [EXP_W-1:0]  r_e, n_e;

    // two serial multiply lanes
    logic [MOD_W-1:0]  r_acc0, n_acc0, r_acc1, n_acc1;
    logic [MOD_W-1:0]  r_x0, n_x0, r_x1, n_x1;
    logic [MOD_W-1:0]  r_y0, n_y0, r_y1, n_y1;

    // extended Euclid
    logic [MOD_W-1:0]        r_ea, n_ea, r_eb, n_eb;
    logic [MOD_W-1:0]        r_rem, n_rem;
    logic signed [SGN_W-1:0] r_u, n_u, r_v, n_v, r_qv, n_qv;

    logic [MOD_W-1:0]  r_res, n_res;
    logic              r_ovalid, n_ovalid;
    logic [MOD_W-1:0]  r_ores, n_ores;

    logic              in_acc;
    logic              out_free;
    logic              last;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign last     = (r_cnt == '0);

    // outputs
    always_comb begin
        i_in.ready   = (r_state == ST_IDLE);
        o_out.valid  = r_ovalid;
        o_out.result = r_ores;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (r_modulus < MOD_W'(2)) ? ST_DONE : ST_RED;
                end
            end
            ST_RED:  if (last) n_state = ST_FIX;
            ST_FIX:  n_state = ST_OP;
            ST_OP: begin
                case (r_kind)
                    KIND_MUL: n_state = ST_MUL;
                    KIND_DIV: n_state = ST_ECHK;
                    KIND_POW: n_state = ST_PCHK;
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_MUL:  if (last) n_state = ST_DONE;
            ST_PCHK: n_state = (r_e == '0) ? ST_DONE : ST_PMUL;
            ST_PMUL: if (last) n_state = ST_PCHK;
            ST_ECHK: n_state = (r_eb == '0) ? ST_INV : ST_EDIV;
            ST_EDIV: if (last) n_state = ST_EUPD;
            ST_EUPD: n_state = ST_ECHK;
            ST_INV:  n_state = ST_MUL;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        logic [MOD_W:0]          ta, tb, sum;
        logic [MOD_W:0]          rem_t;
        logic                    qbit;
        logic signed [SGN_W-1:0] us;
        logic [MOD_W-1:0]        fa, fb;

        n_cnt  = r_cnt;   n_kind = r_kind;
        n_sa   = r_sa;    n_sb   = r_sb;
        n_nega = r_nega;  n_negb = r_negb;
        n_ra   = r_ra;    n_rb   = r_rb;   n_e = r_e;
        n_acc0 = r_acc0;  n_acc1 = r_acc1;
        n_x0   = r_x0;    n_x1   = r_x1;
        n_y0   = r_y0;    n_y1   = r_y1;
        n_ea   = r_ea;    n_eb   = r_eb;   n_rem = r_rem;
        n_u    = r_u;     n_v    = r_v;    n_qv  = r_qv;
        n_res  = r_res;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ores   = r_ores;

        ta = '0; tb = '0; sum = '0; rem_t = '0; qbit = 1'b0; us = '0;
        fa = '0; fb = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // take magnitudes; the most negative value maps to 2^63 unchanged
                    n_kind = i_in.kind;
                    n_nega = i_in.operand_a[OPND_W-1];
                    n_negb = i_in.operand_b[OPND_W-1];
                    n_sa   = i_in.operand_a[OPND_W-1] ? (~i_in.operand_a + 1'b1)
                                                      : i_in.operand_a;
                    n_sb   = i_in.operand_b[OPND_W-1] ? (~i_in.operand_b + 1'b1)
                                                      : i_in.operand_b;
                    n_e    = i_in.exponent;
                    n_ra   = '0;
                    n_rb   = '0;
                    n_res  = '0;
                    n_cnt  = CNT_W'(OPND_W - 1);
                end
            end
            ST_RED: begin
                ta = {r_ra, r_sa[OPND_W-1]};
                tb = {r_rb, r_sb[OPND_W-1]};
                if (ta >= {1'b0, r_modulus}) ta = ta - {1'b0, r_modulus};
                if (tb >= {1'b0, r_modulus}) tb = tb - {1'b0, r_modulus};
                n_ra  = ta[MOD_W-1:0];
                n_rb  = tb[MOD_W-1:0];
                n_sa  = {r_sa[OPND_W-2:0], 1'b0};
                n_sb  = {r_sb[OPND_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end
            ST_FIX: begin
                // negative operand with nonzero residue folds to m - r
                n_ra = (r_nega && r_ra != '0) ? r_modulus - r_ra : r_ra;
                n_rb = (r_negb && r_rb != '0) ? r_modulus - r_rb : r_rb;
            end
            ST_OP: begin
                n_cnt  = CNT_W'(MOD_W - 1);
                n_acc0 = '0;
                n_x0   = r_ra;
                n_y0   = r_rb;
                case (r_kind)
                    KIND_ADD: begin
                        sum = {1'b0, r_ra} + {1'b0, r_rb};
                        if (sum >= {1'b0, r_modulus}) sum = sum - {1'b0, r_modulus};
                        n_res = sum[MOD_W-1:0];
                    end
                    KIND_SUB: begin
                        n_res = (r_ra >= r_rb) ? r_ra - r_rb : r_ra + (r_modulus - r_rb);
                    end
                    KIND_NEG: begin
                        n_res = (r_ra != '0) ? r_modulus - r_ra : '0;
                    end
                    KIND_DIV: begin
                        n_ea = r_rb;
                        n_eb = r_modulus;
                        n_u  = SGN_W'(1);
                        n_v  = '0;
                    end
                    KIND_POW: begin
                        // base in ra, running product in rb
                        n_rb = MOD_W'(1);
                    end
                    default: n_res = '0;
                endcase
            end
            ST_MUL: begin
                n_acc0 = mm_step(r_acc0, r_x0, r_y0[MOD_W-1], r_modulus);
                n_y0   = {r_y0[MOD_W-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (last) n_res = mm_step(r_acc0, r_x0, r_y0[MOD_W-1], r_modulus);
            end
            ST_PCHK: begin
                // lane 0: product * base, lane 1: base * base
                n_res  = r_rb;
                n_acc0 = '0;
                n_acc1 = '0;
                n_x0   = r_ra;
                n_y0   = r_rb;
                n_x1   = r_ra;
                n_y1   = r_ra;
                n_cnt  = CNT_W'(MOD_W - 1);
            end
            ST_PMUL: begin
                fa = mm_step(r_acc0, r_x0, r_y0[MOD_W-1], r_modulus);
                fb = mm_step(r_acc1, r_x1, r_y1[MOD_W-1], r_modulus);
                n_acc0 = fa;
                n_acc1 = fb;
                n_y0   = {r_y0[MOD_W-2:0], 1'b0};
                n_y1   = {r_y1[MOD_W-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (last) begin
                    if (r_e[0]) n_rb = fa;
                    n_ra = fb;
                    n_e  = {1'b0, r_e[EXP_W-1:1]};
                end
            end
            ST_ECHK: begin
                n_rem = '0;
                n_qv  = '0;
                n_cnt = CNT_W'(MOD_W - 1);
            end
            ST_EDIV: begin
                // restoring divide of ea by eb, folding q*v in as quotient bits appear
                rem_t = {r_rem, r_ea[MOD_W-1]};
                qbit  = (rem_t >= {1'b0, r_eb});
                if (qbit) rem_t = rem_t - {1'b0, r_eb};
                n_rem = rem_t[MOD_W-1:0];
                n_ea  = {r_ea[MOD_W-2:0], 1'b0};
                n_qv  = (r_qv <<< 1) + (qbit ? r_v : SGN_W'(0));
                n_cnt = r_cnt - 1'b1;
            end
            ST_EUPD: begin
                n_ea = r_eb;
                n_eb = r_rem;
                n_u  = r_v;
                n_v  = r_u - r_qv;
            end
            ST_INV: begin
                // bring the Bezout coefficient into 0..m-1
                us = r_u + (r_u[SGN_W-1] ? SGN_W'(r_modulus) : SGN_W'(0));
                if (us >= SGN_W'(r_modulus)) us = us - SGN_W'(r_modulus);
                n_acc0 = '0;
                n_x0   = r_ra;
                n_y0   = us[MOD_W-1:0];
                n_cnt  = CNT_W'(MOD_W - 1);
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_modulus <= RESET_MODULUS;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_modulus <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;   r_kind <= n_kind;
        r_sa   <= n_sa;    r_sb   <= n_sb;
        r_nega <= n_nega;  r_negb <= n_negb;
        r_ra   <= n_ra;    r_rb   <= n_rb;   r_e <= n_e;
        r_acc0 <= n_acc0;  r_acc1 <= n_acc1;
        r_x0   <= n_x0;    r_x1   <= n_x1;
        r_y0   <= n_y0;    r_y1   <= n_y1;
        r_ea   <= n_ea;    r_eb   <= n_eb;   r_rem <= n_rem;
        r_u    <= n_u;     r_v    <= n_v;    r_qv  <= n_qv;
        r_res  <= n_res;   r_ores <= n_ores;
    end

`ifndef ASSERT_OFF
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ores < r_modulus || r_modulus < MOD_W'(2)))
        else $error("result not below modulus");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EDIV |-> r_rem < r_eb)
        else $error("divider remainder out of range");

    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PMUL |-> (r_acc0 < r_modulus && r_acc1 < r_modulus))
        else $error("multiply lane out of range");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("second item taken while busy");
`endif

endmodule
